@@ rtl/vgrc_pkg.sv @@
// shared types and constants for the vertical gradient row color block
// no dependencies
`default_nettype none

package vgrc_pkg;

  localparam int FieldBits = 12;
  localparam int RgbBits   = 24;
  localparam int ChanBits  = 8;
  localparam int FactBits  = 8;
  // row * 255 fits in 20 bits
  localparam int NumBits   = FieldBits + FactBits;
  localparam int CfgIdxBits = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_SPAN   = 3'd2,
    REG_ROWS   = 3'd3,
    REG_TOPRGB = 3'd4,
    REG_BOTRGB = 3'd5
  } vgrc_reg_e;

  // payload handed from one divider cell to the next
  typedef struct packed {
    logic                 busy;
    logic                 in_range;
    logic [NumBits-1:0]   rem;
    logic [FieldBits-1:0] div;
    logic [FactBits-1:0]  quo;
    logic [FieldBits-1:0] y;
  } vgrc_div_t;

endpackage

`default_nettype wire

@@ rtl/vertical_gradient_row_color.sv @@
// top level of the vertical gradient row color block
// depends on vgrc_pkg, vgrc_div_cell and vgrc_blend
//
//   port group   direction  handshake               payload
//   request      in         start_i, busy_o         row_index_i
//   result       out        done_o (one cycle)      fill_x_o, fill_y_o, fill_width_o,
//                                                   line_rgb_o, row_valid_o
//   config       in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// one request per clock
// each request passes the 8 divider cells (one factor bit each), then 3 blend stages
// busy_o stays low: every stage moves forward every cycle
// the receiver cannot stall, so nothing is ever held back
// reset clears the configuration and the stage valid bits
`default_nettype none

module vertical_gradient_row_color
  import vgrc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [RgbBits-1:0]    cfg_data_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [FieldBits-1:0]  row_index_i,
  output logic                  done_o,
  output logic [FieldBits-1:0]  fill_x_o,
  output logic [FieldBits-1:0]  fill_y_o,
  output logic [FieldBits-1:0]  fill_width_o,
  output logic [RgbBits-1:0]    line_rgb_o,
  output logic                  row_valid_o
);

  // coordinates wrap at the coordinate range, then fit the 12-bit fields
  localparam int KeepBits = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam logic [FieldBits-1:0] CoordMask = FieldBits'((1 << KeepBits) - 1);

  // configuration registers
  logic [FieldBits-1:0] left_q, top_q, span_q, rows_q;
  logic [RgbBits-1:0]   top_rgb_q, bot_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      top_q     <= '0;
      span_q    <= '0;
      rows_q    <= '0;
      top_rgb_q <= '0;
      bot_rgb_q <= '0;
    end else if (cfg_we_i) begin
      case (vgrc_reg_e'(cfg_idx_i))
        REG_LEFT:   left_q    <= cfg_data_i[FieldBits-1:0];
        REG_TOP:    top_q     <= cfg_data_i[FieldBits-1:0];
        REG_SPAN:   span_q    <= cfg_data_i[FieldBits-1:0];
        REG_ROWS:   rows_q    <= cfg_data_i[FieldBits-1:0];
        REG_TOPRGB: top_rgb_q <= cfg_data_i;
        REG_BOTRGB: bot_rgb_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // the chain never stalls
  assign busy_o = 1'b0;

  // entry into the divider chain: dividend row*255, divisor rows-1
  vgrc_div_t chain [FactBits+1];

  always_comb begin
    chain[0].busy     = start_i;
    chain[0].in_range = row_index_i < rows_q;
    chain[0].rem      = {row_index_i, 8'd0} - NumBits'(row_index_i);
    chain[0].div      = rows_q - 1'b1;
    chain[0].quo      = '0;
    chain[0].y        = (top_q + row_index_i) & CoordMask;
  end

  // factor is below 256, so eight cells settle it msb first
  for (genvar k = 0; k < FactBits; k++) begin : g_cell
    vgrc_div_cell #(
      .STEP(FactBits - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (chain[k]),
      .pipe_o (chain[k+1])
    );
  end

  // colors and geometry read live: user changes config only when idle (not enforced)
  vgrc_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_i       (chain[FactBits]),
    .top_rgb_i    (top_rgb_q),
    .bot_rgb_i    (bot_rgb_q),
    .left_i       (left_q & CoordMask),
    .span_i       (span_q & CoordMask),
    .done_o       (done_o),
    .fill_x_o     (fill_x_o),
    .fill_y_o     (fill_y_o),
    .fill_width_o (fill_width_o),
    .line_rgb_o   (line_rgb_o),
    .row_valid_o  (row_valid_o)
  );

endmodule

`default_nettype wire

@@ rtl/vgrc_div_cell.sv @@
// one restoring divider cell: resolves one bit of the blend factor
// depends on vgrc_pkg
`default_nettype none

module vgrc_div_cell
  import vgrc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vgrc_div_t pipe_i,
  output vgrc_div_t pipe_o
);

  logic [NumBits-1:0] trial;
  logic               ge;
  vgrc_div_t          pipe_d, data_q;
  logic               busy_q;

  always_comb begin
    trial  = NumBits'(pipe_i.div) << STEP;
    // zero divisor means single row, factor stays zero
    ge     = (pipe_i.rem >= trial) && (pipe_i.div != '0);
    pipe_d = pipe_i;
    pipe_d.rem = ge ? (pipe_i.rem - trial) : pipe_i.rem;
    pipe_d.quo = {pipe_i.quo[FactBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= pipe_d.busy;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= pipe_d;
  end

  // valid bit comes from the reset flop, payload from the plain one
  always_comb begin
    pipe_o      = data_q;
    pipe_o.busy = busy_q;
  end

endmodule

`default_nettype wire

@@ rtl/vgrc_blend.sv @@
// color blend stages: weighted sum, divide by 255, output register
// depends on vgrc_pkg
`default_nettype none

module vgrc_blend
  import vgrc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vgrc_div_t            pipe_i,
  input  logic [RgbBits-1:0]   top_rgb_i,
  input  logic [RgbBits-1:0]   bot_rgb_i,
  input  logic [FieldBits-1:0] left_i,
  input  logic [FieldBits-1:0] span_i,
  output logic                 done_o,
  output logic [FieldBits-1:0] fill_x_o,
  output logic [FieldBits-1:0] fill_y_o,
  output logic [FieldBits-1:0] fill_width_o,
  output logic [RgbBits-1:0]   line_rgb_o,
  output logic                 row_valid_o
);

  localparam int SumBits = 2 * ChanBits;

  // stage a: weighted sums
  logic                 a_busy_q, a_range_q;
  logic [FieldBits-1:0] a_y_q;
  logic [SumBits-1:0]   a_sum_q [3];
  // stage b: reciprocal estimate
  logic                 b_busy_q, b_range_q;
  logic [FieldBits-1:0] b_y_q;
  logic [SumBits-1:0]   b_sum_q [3];
  logic [ChanBits-1:0]  b_est_q [3];
  // output register
  logic                 o_busy_q, o_range_q;
  logic [FieldBits-1:0] o_y_q, o_x_q, o_w_q;
  logic [ChanBits-1:0]  o_chan_q [3];

  logic [SumBits-1:0]   a_sum_d [3];
  logic [ChanBits-1:0]  b_est_d [3];
  logic [ChanBits-1:0]  o_chan_d [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [ChanBits-1:0]   hi, lo, inv;
    logic [SumBits+7:0]    scaled;
    logic [SumBits:0]      back, resid;
    always_comb begin
      hi  = top_rgb_i[c*ChanBits +: ChanBits];
      lo  = bot_rgb_i[c*ChanBits +: ChanBits];
      inv = ~pipe_i.quo;
      a_sum_d[c] = SumBits'(hi * inv) + SumBits'(lo * pipe_i.quo);
      // x * 257 / 65536, at most one below x / 255
      scaled     = {a_sum_q[c], 8'd0} + (SumBits+8)'(a_sum_q[c]);
      b_est_d[c] = scaled[SumBits+7:SumBits];
      back       = {1'b0, b_est_q[c], 8'd0} - (SumBits+1)'(b_est_q[c]);
      resid      = {1'b0, b_sum_q[c]} - back;
      o_chan_d[c] = (resid >= (SumBits+1)'(255)) ? b_est_q[c] + 1'b1 : b_est_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_busy_q <= 1'b0;
      b_busy_q <= 1'b0;
      o_busy_q <= 1'b0;
    end else begin
      a_busy_q <= pipe_i.busy;
      b_busy_q <= a_busy_q;
      o_busy_q <= b_busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_range_q <= pipe_i.in_range;
    a_y_q     <= pipe_i.y;
    b_range_q <= a_range_q;
    b_y_q     <= a_y_q;
    o_range_q <= b_range_q;
    o_y_q     <= b_y_q;
    o_x_q     <= left_i;
    o_w_q     <= span_i;
    for (int c = 0; c < 3; c++) begin
      a_sum_q[c]  <= a_sum_d[c];
      b_sum_q[c]  <= a_sum_q[c];
      b_est_q[c]  <= b_est_d[c];
      o_chan_q[c] <= o_chan_d[c];
    end
  end

  // rows out of range report all zero fields
  assign done_o       = o_busy_q;
  assign row_valid_o  = o_range_q;
  assign fill_x_o     = o_range_q ? o_x_q : '0;
  assign fill_y_o     = o_range_q ? o_y_q : '0;
  assign fill_width_o = o_range_q ? o_w_q : '0;
  assign line_rgb_o   = o_range_q ? {o_chan_q[2], o_chan_q[1], o_chan_q[0]} : '0;

endmodule

`default_nettype wire
